// File: rtl/core/pdc_pkg.sv
// shared constants, codes and command types for the pid duty controller
package pdc_pkg;

   // default geometry
   localparam int SAMPLE_WIDTH_DEF = 10;
   localparam int FRAC_BITS_DEF    = 24;

   // fixed field and register widths
   localparam int FS_WIDTH        = 10;
   localparam int GAIN_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int INTEG_WIDTH     = 48;
   localparam int SUM_WIDTH       = 64;
   localparam int DUTY_WIDTH      = 7;
   localparam int SCALE_BITS      = 7;

   // duty scaling and limits
   localparam int PERCENT_SCALE = 100;
   localparam int DUTY_LIMIT    = 100;
   localparam int DUTY_MAX      = 99;

   // register reset values
   localparam logic [FS_WIDTH-1:0]   FULL_SCALE_RST = 10'd900;
   localparam logic [GAIN_WIDTH-1:0] GAIN_PROP_RST  = 32'd6710886;
   localparam logic [GAIN_WIDTH-1:0] GAIN_INTEG_RST = 32'd3355;
   localparam logic [GAIN_WIDTH-1:0] GAIN_DERIV_RST = 32'd0;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FULL_SCALE = 2'd0,
      CSR_GAIN_PROP  = 2'd1,
      CSR_GAIN_INTEG = 2'd2,
      CSR_GAIN_DERIV = 2'd3
   } csr_index_type;

   // multiplier operand select
   typedef enum logic [1:0] {
      MS_INTEG = 2'd0,
      MS_PROP  = 2'd1,
      MS_DERIV = 2'd2
   } mul_sel_type;

   // accumulator operation
   typedef enum logic [1:0] {
      ACC_HOLD    = 2'd0,
      ACC_FF_PROD = 2'd1,
      ACC_PROD    = 2'd2,
      ACC_INTEG   = 2'd3
   } acc_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        prod_en;
      mul_sel_type mul_sel;
      logic        integ_upd;
      acc_op_type  acc_op;
      logic        out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// File: rtl/core/pdc_if.sv
// request and response channel interfaces of the pid duty controller
interface pdc_req_if #(
   parameter int SAMPLE_WIDTH = pdc_pkg::SAMPLE_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] target_speed;
   logic [SAMPLE_WIDTH-1:0] measured_speed;

   modport source (output valid, output target_speed, output measured_speed, input ready);
   modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface pdc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pdc_pkg::DUTY_WIDTH-1:0]  duty_percent;
   logic                            clamped;

   modport source (output valid, output duty_percent, output clamped, input ready);
   modport sink   (input valid, input duty_percent, input clamped, output ready);
endinterface

// File: rtl/core/pdc_ctrl.sv
// sequencing state machine of the pid duty controller
module pdc_ctrl #(
   parameter int SAMPLE_WIDTH = pdc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pdc_pkg::sts_type sts,
   output pdc_pkg::cmd_type cmd
);

   localparam int NUM_W = SAMPLE_WIDTH + pdc_pkg::SCALE_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_MUL_I = 8'b0000_0100,
      ST_MUL_P = 8'b0000_1000,
      ST_MUL_D = 8'b0001_0000,
      ST_ADD_D = 8'b0010_0000,
      ST_ADD_I = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state and divide step count
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
               cnt_in   = CNT_W'(NUM_W - 1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_MUL_I;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL_I: state_in = ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_ADD_D;
         ST_ADD_D: state_in = ST_ADD_I;
         ST_ADD_I: state_in = ST_OUT;
         ST_OUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // command decode
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = pdc_pkg::MS_INTEG;
      cmd.acc_op    = pdc_pkg::ACC_HOLD;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.integ_upd = (state_ff == ST_MUL_P);
      cmd.out_load  = (state_ff == ST_OUT) && sts.out_free;
      case (state_ff)
         ST_MUL_I: begin
            cmd.prod_en = 1'b1;
            cmd.mul_sel = pdc_pkg::MS_INTEG;
         end
         ST_MUL_P: begin
            cmd.prod_en = 1'b1;
            cmd.mul_sel = pdc_pkg::MS_PROP;
         end
         ST_MUL_D: begin
            cmd.prod_en = 1'b1;
            cmd.mul_sel = pdc_pkg::MS_DERIV;
            cmd.acc_op  = pdc_pkg::ACC_FF_PROD;
         end
         ST_ADD_D: cmd.acc_op = pdc_pkg::ACC_PROD;
         ST_ADD_I: cmd.acc_op = pdc_pkg::ACC_INTEG;
         default:  cmd.acc_op = pdc_pkg::ACC_HOLD;
      endcase
   end

endmodule

// File: rtl/core/pdc_datapath.sv
// divider, shared multiplier, integrator, accumulator and output word register
module pdc_datapath #(
   parameter int SAMPLE_WIDTH = pdc_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = pdc_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pdc_pkg::cmd_type                   cmd,
   output pdc_pkg::sts_type                   sts,
   input  logic [SAMPLE_WIDTH-1:0]            target_speed,
   input  logic [SAMPLE_WIDTH-1:0]            measured_speed,
   input  logic [pdc_pkg::FS_WIDTH-1:0]       full_scale,
   input  logic [pdc_pkg::GAIN_WIDTH-1:0]     gain_prop,
   input  logic [pdc_pkg::GAIN_WIDTH-1:0]     gain_integ,
   input  logic [pdc_pkg::GAIN_WIDTH-1:0]     gain_deriv,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [pdc_pkg::DUTY_WIDTH-1:0]     duty_percent,
   output logic                               clamped
);

   localparam int ERR_W   = SAMPLE_WIDTH + 1;
   localparam int DIFF_W  = SAMPLE_WIDTH + 2;
   localparam int NUM_W   = SAMPLE_WIDTH + pdc_pkg::SCALE_BITS;
   localparam int REM_W   = pdc_pkg::FS_WIDTH + 1;
   localparam int OPB_W   = pdc_pkg::GAIN_WIDTH + 1;
   localparam int PROD_W  = DIFF_W + OPB_W;
   localparam int SUM_W   = pdc_pkg::SUM_WIDTH;
   localparam int INTEG_W = pdc_pkg::INTEG_WIDTH;
   localparam int DUTY_W  = pdc_pkg::DUTY_WIDTH;

   localparam logic signed [SUM_W-1:0] INTEG_HI = (SUM_W'(1) << (INTEG_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] INTEG_LO = -(SUM_W'(1) << (INTEG_W - 1));
   localparam logic signed [SUM_W-1:0] LOW_LIM  = -(SUM_W'(1) << FRAC_BITS);
   localparam logic signed [SUM_W-1:0] HIGH_LIM = SUM_W'(pdc_pkg::DUTY_LIMIT) << FRAC_BITS;

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic [NUM_W-1:0]          quot_ff, quot_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]         duty_ff, duty_in;
   logic                      clamped_ff, clamped_in;

   logic [REM_W-1:0]          rem_sh;
   logic                      rem_ge;
   logic [NUM_W-1:0]          ff_val;
   logic signed [DIFF_W-1:0]  op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [SUM_W-1:0]   prod_ext;
   logic signed [SUM_W-1:0]   integ_ext;
   logic signed [SUM_W-1:0]   integ_sum;
   logic signed [SUM_W-1:0]   ff_term;
   logic                      clamp_lo;
   logic                      clamp_hi;

   // error and error change, taken when a word is accepted
   assign err_in  = $signed({1'b0, target_speed}) - $signed({1'b0, measured_speed});
   assign diff_in = DIFF_W'(err_in) - DIFF_W'(prev_err_ff);

   // restoring divider step, one quotient bit per cycle
   assign rem_sh = {rem_ff[REM_W-2:0], quot_ff[NUM_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, full_scale});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         quot_in = NUM_W'(target_speed) * NUM_W'(pdc_pkg::PERCENT_SCALE);
         rem_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[NUM_W-2:0], rem_ge};
         rem_in  = rem_ge ? (rem_sh - {1'b0, full_scale}) : rem_sh;
      end
   end

   // zero full scale gives no feedforward
   assign ff_val = (full_scale != '0) ? quot_ff : '0;

   // shared multiplier, error or error change by one gain
   always_comb begin
      case (cmd.mul_sel)
         pdc_pkg::MS_PROP: begin
            op_a = DIFF_W'(err_ff);
            op_b = $signed({1'b0, gain_prop});
         end
         pdc_pkg::MS_DERIV: begin
            op_a = diff_ff;
            op_b = $signed({1'b0, gain_deriv});
         end
         default: begin
            op_a = DIFF_W'(err_ff);
            op_b = $signed({1'b0, gain_integ});
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // integrator with saturation
   assign prod_ext  = {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign integ_ext = {{(SUM_W - INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};
   assign integ_sum = integ_ext + prod_ext;

   always_comb begin
      if (integ_sum > INTEG_HI) begin
         integ_in = INTEG_HI[INTEG_W-1:0];
      end else if (integ_sum < INTEG_LO) begin
         integ_in = INTEG_LO[INTEG_W-1:0];
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   // accumulator for feedforward and pid terms
   assign ff_term = SUM_W'(ff_val) << FRAC_BITS;

   always_comb begin
      case (cmd.acc_op)
         pdc_pkg::ACC_FF_PROD: acc_in = ff_term + prod_ext;
         pdc_pkg::ACC_PROD:    acc_in = acc_ff + prod_ext;
         pdc_pkg::ACC_INTEG:   acc_in = acc_ff + integ_ext;
         default:              acc_in = acc_ff;
      endcase
   end

   // truncate toward zero and clamp to the duty range
   assign clamp_lo = (acc_ff <= LOW_LIM);
   assign clamp_hi = (acc_ff >= HIGH_LIM);

   always_comb begin
      clamped_in = clamp_lo || clamp_hi;
      if (clamp_hi) begin
         duty_in = DUTY_W'(pdc_pkg::DUTY_MAX);
      end else if (acc_ff[SUM_W-1]) begin
         duty_in = '0;
      end else begin
         duty_in = acc_ff[FRAC_BITS +: DUTY_W];
      end
   end

   // output word register
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            prev_err_ff <= err_in;
         end
         if (cmd.integ_upd) begin
            integ_ff <= integ_in;
         end
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.prod_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         duty_ff    <= duty_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign duty_percent = duty_ff;
   assign clamped      = clamped_ff;

endmodule

// File: rtl/core/pid_duty_controller_core.sv
// top level of the pid duty controller with feedforward
//
//   channel   dir   handshake        payload
//   req_port  in    valid / ready    target_speed, measured_speed
//   rsp_port  out   valid / ready    duty_percent, clamped
//   csr_*     in    csr_we           csr_index, csr_wdata
//
// one word is in flight at a time; it passes through the divide steps, the three
// multiply states and the two add states before the result is loaded, and the
// next word can be taken in the cycle after the load
// the restoring divider for the feedforward takes one quotient bit per cycle,
// and the single shared multiplier takes three passes
// reset is synchronous and active high; it clears the integrator and error history
// a result waits in the output register while the next word is accepted; the
// block stalls only at its final step until that register is free
module pid_duty_controller_core #(
   parameter int SAMPLE_WIDTH = pdc_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = pdc_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pdc_req_if.sink                              req_port,
   pdc_rsp_if.source                            rsp_port,
   input  logic                                 csr_we,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [pdc_pkg::FS_WIDTH-1:0]   full_scale_ff;
   logic [pdc_pkg::GAIN_WIDTH-1:0] gain_prop_ff;
   logic [pdc_pkg::GAIN_WIDTH-1:0] gain_integ_ff;
   logic [pdc_pkg::GAIN_WIDTH-1:0] gain_deriv_ff;

   pdc_pkg::cmd_type cmd;
   pdc_pkg::sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= pdc_pkg::FULL_SCALE_RST;
         gain_prop_ff  <= pdc_pkg::GAIN_PROP_RST;
         gain_integ_ff <= pdc_pkg::GAIN_INTEG_RST;
         gain_deriv_ff <= pdc_pkg::GAIN_DERIV_RST;
      end else if (csr_we) begin
         case (csr_index)
            pdc_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata[pdc_pkg::FS_WIDTH-1:0];
            pdc_pkg::CSR_GAIN_PROP:  gain_prop_ff  <= csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            pdc_pkg::CSR_GAIN_INTEG: gain_integ_ff <= csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            pdc_pkg::CSR_GAIN_DERIV: gain_deriv_ff <= csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // controller
   pdc_ctrl #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   pdc_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .target_speed   (req_port.target_speed),
      .measured_speed (req_port.measured_speed),
      .full_scale     (full_scale_ff),
      .gain_prop      (gain_prop_ff),
      .gain_integ     (gain_integ_ff),
      .gain_deriv     (gain_deriv_ff),
      .rsp_ready      (rsp_port.ready),
      .rsp_valid      (rsp_port.valid),
      .duty_percent   (rsp_port.duty_percent),
      .clamped        (rsp_port.clamped)
   );

   // checks
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_port.ready)
      else $error("request ready while a word is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a word not yet taken");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.duty_percent <= pdc_pkg::DUTY_WIDTH'(pdc_pkg::DUTY_MAX)))
      else $error("duty out of range");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.clamped) |->
         (rsp_port.duty_percent == '0 ||
          rsp_port.duty_percent == pdc_pkg::DUTY_WIDTH'(pdc_pkg::DUTY_MAX)))
      else $error("clamped word with a duty other than a limit");

endmodule

// File: tb/pid_duty_controller_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the pid duty controller core with a duty predictor
module pid_duty_controller_core_tb;

   localparam int SW          = pdc_pkg::SAMPLE_WIDTH_DEF;
   localparam int FB          = pdc_pkg::FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 40;
   localparam longint INTEG_HI = (longint'(1) <<< (pdc_pkg::INTEG_WIDTH - 1)) - 1;
   localparam longint INTEG_LO = -INTEG_HI - 1;

   // how the two sides of the block idle during a phase
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idling_mode_type;

   typedef struct packed {
      logic [pdc_pkg::DUTY_WIDTH-1:0] duty;
      logic                           clamped;
   } duty_word_type;

   // predicts the duty of each accepted word and checks the returned words
   class duty_tracker_type;
      logic [pdc_pkg::FS_WIDTH-1:0]   full_scale;
      logic [pdc_pkg::GAIN_WIDTH-1:0] gain_prop;
      logic [pdc_pkg::GAIN_WIDTH-1:0] gain_integ;
      logic [pdc_pkg::GAIN_WIDTH-1:0] gain_deriv;
      longint                         integ_acc;
      longint                         last_error;
      duty_word_type                  expected_duty[$];
      int                             errors;
      int                             words_seen;

      function new();
         full_scale = pdc_pkg::FULL_SCALE_RST;
         gain_prop  = pdc_pkg::GAIN_PROP_RST;
         gain_integ = pdc_pkg::GAIN_INTEG_RST;
         gain_deriv = pdc_pkg::GAIN_DERIV_RST;
         integ_acc  = 0;
         last_error = 0;
         errors     = 0;
         words_seen = 0;
      endfunction

      function void set_registers(logic [pdc_pkg::FS_WIDTH-1:0] fs,
                                  logic [pdc_pkg::GAIN_WIDTH-1:0] kp,
                                  logic [pdc_pkg::GAIN_WIDTH-1:0] ki,
                                  logic [pdc_pkg::GAIN_WIDTH-1:0] kd);
         full_scale = fs;
         gain_prop  = kp;
         gain_integ = ki;
         gain_deriv = kd;
      endfunction

      function int pending();
         return expected_duty.size();
      endfunction

      function void note_sample(logic [SW-1:0] target, logic [SW-1:0] measured);
         longint        feed;
         longint        err;
         longint        diff_term;
         longint        prop_term;
         longint        total;
         longint        whole;
         duty_word_type word;
         // feedforward percent, zero when full scale is zero
         feed = 0;
         if (full_scale != 0)
            feed = (longint'(target) * pdc_pkg::PERCENT_SCALE) / longint'(full_scale);
         err = longint'(target) - longint'(measured);
         diff_term = (err - last_error) * longint'(gain_deriv);
         last_error = err;
         // integrator saturates at the signed accumulator limits
         integ_acc = integ_acc + err * longint'(gain_integ);
         if (integ_acc > INTEG_HI)
            integ_acc = INTEG_HI;
         if (integ_acc < INTEG_LO)
            integ_acc = INTEG_LO;
         prop_term = err * longint'(gain_prop);
         total = (feed <<< FB) + integ_acc + diff_term + prop_term;
         // truncate toward zero, then clamp into the duty range
         if (total < 0)
            whole = -((-total) >>> FB);
         else
            whole = total >>> FB;
         if (whole < 0) begin
            word.duty    = '0;
            word.clamped = 1'b1;
         end else if (whole >= pdc_pkg::DUTY_LIMIT) begin
            word.duty    = pdc_pkg::DUTY_WIDTH'(pdc_pkg::DUTY_MAX);
            word.clamped = 1'b1;
         end else begin
            word.duty    = whole[pdc_pkg::DUTY_WIDTH-1:0];
            word.clamped = 1'b0;
         end
         expected_duty.push_back(word);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("duty word %0d: %s got %0d want %0d", words_seen, what, got, want);
         errors++;
      endtask

      task check_duty(logic [pdc_pkg::DUTY_WIDTH-1:0] duty, logic clamped);
         duty_word_type want;
         words_seen++;
         if (expected_duty.size() == 0) begin
            report_mismatch("unexpected word, duty", duty, -1);
         end else begin
            want = expected_duty.pop_front();
            if (duty !== want.duty)
               report_mismatch("duty_percent", duty, want.duty);
            if (clamped !== want.clamped)
               report_mismatch("clamped", clamped, want.clamped);
         end
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_we;
   pdc_pkg::csr_index_type             csr_index;
   logic [pdc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;
   int                                 idle_pct;
   int                                 stall_pct;
   int                                 cycle_count;
   duty_tracker_type                   tracker = new();

   pdc_req_if #(.SAMPLE_WIDTH(SW)) req_if ();
   pdc_rsp_if                      rsp_if ();

   pid_duty_controller_core #(
      .SAMPLE_WIDTH(SW),
      .FRAC_BITS   (FB)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         tracker.check_duty(rsp_if.duty_percent, rsp_if.clamped);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // write one register, leaving the enable high
   task automatic put_register(pdc_pkg::csr_index_type idx,
                               logic [pdc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // write all four registers while the block is idle
   task automatic apply_settings(logic [pdc_pkg::FS_WIDTH-1:0] fs,
                                 logic [pdc_pkg::GAIN_WIDTH-1:0] kp,
                                 logic [pdc_pkg::GAIN_WIDTH-1:0] ki,
                                 logic [pdc_pkg::GAIN_WIDTH-1:0] kd);
      // upper bits of the full scale word are junk that the block drops
      put_register(pdc_pkg::CSR_FULL_SCALE,
                   ($urandom() & ~32'h3FF) | pdc_pkg::CSR_DATA_WIDTH'(fs));
      put_register(pdc_pkg::CSR_GAIN_PROP, kp);
      put_register(pdc_pkg::CSR_GAIN_INTEG, ki);
      put_register(pdc_pkg::CSR_GAIN_DERIV, kd);
      csr_we <= 1'b0;
      tracker.set_registers(fs, kp, ki, kd);
   endtask

   // offer one word after a random gap and wait for it to be taken
   task automatic send_sample(logic [SW-1:0] target, logic [SW-1:0] measured);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.target_speed   <= target;
      req_if.measured_speed <= measured;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_sample(target, measured);
   endtask

   // hold off the sender until every expected duty has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   function automatic int extreme_speed();
      case ($urandom_range(3))
         0:       return 0;
         1:       return (1 << SW) - 1;
         2:       return 1;
         default: return (1 << SW) - 2;
      endcase
   endfunction

   // mostly a loop near lock, some noise and extremes; lean forces the error sign but for noise
   task automatic pick_speeds(input int lean, output logic [SW-1:0] target,
                              output logic [SW-1:0] measured);
      int full_count;
      int kind;
      int t;
      int m;
      full_count = (1 << SW) - 1;
      kind = $urandom_range(9);
      t = $urandom_range(full_count);
      if (kind == 0) begin
         m = $urandom_range(full_count);
      end else if (lean > 0) begin
         t = $urandom_range(full_count, full_count - 63);
         m = $urandom_range(63);
      end else if (lean < 0) begin
         t = $urandom_range(63);
         m = $urandom_range(full_count, full_count - 63);
      end else if (kind == 1) begin
         t = extreme_speed();
         m = extreme_speed();
      end else begin
         m = t + $urandom_range(80) - 40;
         if (m < 0)
            m = 0;
         if (m > full_count)
            m = full_count;
      end
      target   = t[SW-1:0];
      measured = m[SW-1:0];
   endtask

   // one stretch of random words under one register setting
   task automatic run_phase(int count, idling_mode_type mode, bit split_lean);
      logic [SW-1:0] target;
      logic [SW-1:0] measured;
      int            lean;
      case (mode)
         IDLE_NONE: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            idle_pct  = 64;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            idle_pct  = 0;
            stall_pct = 64;
         end
         default: begin
            idle_pct  = 12;
            stall_pct = 12;
         end
      endcase
      for (int i = 0; i < count; i++) begin
         lean = 0;
         if (split_lean)
            lean = (i < count * 2 / 5) ? 1 : -1;
         pick_speeds(lean, target, measured);
         send_sample(target, measured);
         if ($urandom_range(49) == 0)
            drain_results();
      end
      drain_results();
   endtask

   // run watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pid_duty_controller_core_tb NOT OK");
      $finish;
   end

   // stimulus
   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.target_speed   = '0;
      req_if.measured_speed = '0;
      csr_we                = 1'b0;
      csr_index             = pdc_pkg::CSR_FULL_SCALE;
      csr_wdata             = '0;
      idle_pct              = 0;
      stall_pct             = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero full scale with a tiny gain: a sum just below zero is not clamped
      apply_settings(10'd0, 32'd1, 32'd0, 32'd0);
      send_sample(10'd0, 10'd1);
      send_sample(10'd0, 10'd0);
      send_sample(10'd1023, 10'd0);
      drain_results();

      // zero full scale with unit gain: the pid part alone drives the duty
      apply_settings(10'd0, 32'h0100_0000, 32'd0, 32'd0);
      send_sample(10'd60, 10'd0);
      send_sample(10'd0, 10'd60);
      send_sample(10'd200, 10'd0);
      drain_results();

      // reset settings at the field extremes
      apply_settings(pdc_pkg::FULL_SCALE_RST, pdc_pkg::GAIN_PROP_RST,
                     pdc_pkg::GAIN_INTEG_RST, pdc_pkg::GAIN_DERIV_RST);
      send_sample(10'd0, 10'd0);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd900, 10'd900);
      send_sample(10'd450, 10'd450);
      send_sample(10'd1, 10'd0);
      send_sample(10'd0, 10'd1);
      send_sample(10'd512, 10'd511);
      send_sample(10'd1022, 10'd1023);
      drain_results();

      // random phases, the saturating integrator last
      apply_settings(pdc_pkg::FULL_SCALE_RST, pdc_pkg::GAIN_PROP_RST,
                     pdc_pkg::GAIN_INTEG_RST, pdc_pkg::GAIN_DERIV_RST);
      run_phase(110, IDLE_NONE, 1'b0);
      apply_settings(10'd1023, 32'hFFFF_FFFF, 32'd0, 32'd0);
      run_phase(110, IDLE_SENDER, 1'b0);
      apply_settings(pdc_pkg::FS_WIDTH'($urandom_range(1023, 1)), $urandom_range(1 << 26),
                     $urandom_range(1 << 16), $urandom_range(1 << 26));
      run_phase(110, IDLE_RECEIVER, 1'b0);
      apply_settings(10'd0, $urandom_range(1 << 25), 32'd0, $urandom_range(1 << 24));
      run_phase(110, IDLE_BOTH, 1'b0);
      apply_settings(10'd1, 32'd0, 32'd0, 32'hFFFF_FFFF);
      run_phase(110, IDLE_SENDER, 1'b0);
      apply_settings(pdc_pkg::FS_WIDTH'($urandom_range(1023, 1)), 32'd0, 32'hFFFF_FFFF,
                     32'd0);
      run_phase(200, IDLE_RECEIVER, 1'b1);

      repeat (SETTLE) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("pid_duty_controller_core_tb OK");
      else
         $display("pid_duty_controller_core_tb NOT OK");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/pdc_pkg.sv
rtl/core/pdc_if.sv
rtl/core/pdc_ctrl.sv
rtl/core/pdc_datapath.sv
rtl/core/pid_duty_controller_core.sv
tb/pid_duty_controller_core_tb.sv
